// ===== hdl/cbs_pkg.sv =====
// Package for the cubic Bezier sub-curve unit: beat types, fixed-point constants and lerp.
// Depends on nothing; used by cbs_div and cubic_bezier_subcurve_unit.
package cbs_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned TW     = 17;
  localparam logic [TW-1:0] TOne = 17'h10000;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [TW-1:0] tq_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t ctrl_a_x;
    coord_t ctrl_a_y;
    coord_t ctrl_b_x;
    coord_t ctrl_b_y;
    coord_t end_x;
    coord_t end_y;
    tq_t    t_from;
    tq_t    t_to;
  } in_beat_t;

  typedef struct packed {
    coord_t sub_start_x;
    coord_t sub_start_y;
    coord_t sub_ctrl_a_x;
    coord_t sub_ctrl_a_y;
    coord_t sub_ctrl_b_x;
    coord_t sub_ctrl_b_y;
    coord_t sub_end_x;
    coord_t sub_end_y;
  } out_beat_t;

  typedef enum logic [1:0] {
    MODE_SPLIT = 2'd0,
    MODE_PASS  = 2'd1,
    MODE_END   = 2'd2,
    MODE_START = 2'd3
  } mode_e;

  // a + round((b - a) * t / 2^16), ties toward +inf; result stays between a and b
  function automatic coord_t lerp(coord_t a, coord_t b, tq_t t);
    logic signed [CoordW:0]      diff;
    logic signed [CoordW+TW+1:0] prod;
    logic signed [CoordW+TW+1:0] sh;
    diff = {a[CoordW-1], a} - {b[CoordW-1], b};
    diff = -diff;
    prod = diff * $signed({1'b0, t}) + (CoordW+TW+2)'(32768);
    sh   = prod >>> 16;
    return coord_t'(a + sh[CoordW-1:0]);
  endfunction

endpackage

// ===== hdl/cbs_div.sv =====
// Pipelined restoring divider: q = (num * 2^16 + d/2) / d, one quotient bit per stage.
// Depends on cbs_pkg.
module cbs_div import cbs_pkg::*; #(
  parameter int unsigned Stages = 17
) (
  input  logic          clk_i,
  input  logic [TW-1:0] num_i,
  input  logic [TW-1:0] den_i,
  output logic [TW-1:0] quo_o
);
  // dividend < 2^34, quotient fits 17 bits since num <= den
  localparam int unsigned NW = 34;

  logic [NW-1:0] rem_q [Stages+1];
  logic [TW-1:0] den_q [Stages+1];
  logic [TW-1:0] quo_q [Stages+1];
  logic [NW-1:0] dvd_q [Stages+1];

  // the upper dividend bits are already below the divisor; start from them
  always_comb begin
    dvd_q[0] = {1'b0, num_i, 16'h0} + NW'(den_i >> 1);
    rem_q[0] = NW'(dvd_q[0][NW-1:Stages]);
    den_q[0] = den_i;
    quo_q[0] = '0;
  end

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [NW:0] rem_d;
    logic [NW:0] sub_d;
    always_comb begin
      rem_d = {rem_q[s], dvd_q[s][Stages-1-s]};
      sub_d = rem_d - (NW+1)'(den_q[s]);
    end
    always_ff @(posedge clk_i) begin
      if (!sub_d[NW]) begin
        rem_q[s+1] <= sub_d[NW-1:0];
        quo_q[s+1] <= {quo_q[s][TW-2:0], 1'b1};
      end else begin
        rem_q[s+1] <= rem_d[NW-1:0];
        quo_q[s+1] <= {quo_q[s][TW-2:0], 1'b0};
      end
      den_q[s+1] <= den_q[s];
      dvd_q[s+1] <= dvd_q[s];
    end
  end

  assign quo_o = quo_q[Stages];

endmodule

// ===== hdl/cubic_bezier_subcurve_unit.sv =====
// Top level of the cubic Bezier sub-curve unit: clamp, split, divide, second split.
// Depends on cbs_pkg and cbs_div.
//
// Usage: drive in_i and pulse start_i; busy_o is always low, so a beat is
// taken at every edge with start_i high - one curve per cycle, back to back.
// The result appears on out_o with done_o high for exactly one cycle after
// passing 1 clamp/classify stage, the 17-stage divider for the renormalized
// end (the 3-stage first de Casteljau split runs alongside it and its right
// half waits in a delay line), 3 stages of the second split, one output
// register. The divider's one-bit-per-stage chain sets the latency.
// Throughput is one beat per cycle; the receiver cannot stall, so no beat
// ever waits. Reset clears the valid bits of every stage and done_o; the
// payload registers are not reset. Special cases (full interval, start at
// one, empty interval) ride as a mode code beside the data and select the
// output in the last stage.
module cubic_bezier_subcurve_unit import cbs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_beat_t  in_i,
  output logic      busy_o,
  output logic      done_o,
  output out_beat_t out_o
);
  localparam int unsigned DivStages = 17;
  // stages 1..Lat-1 carry data; split-1 finishes at 4, split-2 starts after divider
  localparam int unsigned Lat = DivStages + 5;

  typedef coord_t pts_t [2][4];

  // valid bit chain
  logic [Lat-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start_i};
    end
  end
  assign busy_o = 1'b0;
  assign done_o = vld_q[Lat-1];

  // stage 1: clamp t, classify
  tq_t   t1_d, t2_d;
  mode_e mode_d;
  always_comb begin
    t1_d = (in_i.t_from > TOne) ? TOne : in_i.t_from;
    t2_d = (in_i.t_to > TOne) ? TOne : in_i.t_to;
    if (t1_d == '0 && t2_d == TOne) begin
      mode_d = MODE_PASS;
    end else if (t1_d == TOne) begin
      mode_d = MODE_END;
    end else if (t2_d == '0 || t1_d >= t2_d) begin
      mode_d = MODE_START;
    end else begin
      mode_d = MODE_SPLIT;
    end
  end

  tq_t   t1_q;
  pts_t  p_q;
  mode_e mode_q [Lat];
  pts_t  org_q  [Lat];
  always_ff @(posedge clk_i) begin
    t1_q      <= t1_d;
    mode_q[1] <= mode_d;
    p_q[0][0] <= in_i.start_x;  p_q[1][0] <= in_i.start_y;
    p_q[0][1] <= in_i.ctrl_a_x; p_q[1][1] <= in_i.ctrl_a_y;
    p_q[0][2] <= in_i.ctrl_b_x; p_q[1][2] <= in_i.ctrl_b_y;
    p_q[0][3] <= in_i.end_x;    p_q[1][3] <= in_i.end_y;
    org_q[1]  <= '{'{in_i.start_x, in_i.ctrl_a_x, in_i.ctrl_b_x, in_i.end_x},
                   '{in_i.start_y, in_i.ctrl_a_y, in_i.ctrl_b_y, in_i.end_y}};
  end

  // divider starts from stage-1 clamped values; num is zeroed outside split mode, so num<=den always holds
  logic [TW-1:0] nt;
  tq_t           dnum_q, dden_q;
  always_ff @(posedge clk_i) begin
    dnum_q <= (mode_d == MODE_SPLIT) ? tq_t'(t2_d - t1_d) : '0;
    dden_q <= tq_t'(TOne - t1_d);
  end
  cbs_div #(.Stages(DivStages)) u_div (
    .clk_i (clk_i),
    .num_i (dnum_q),
    .den_i (dden_q),
    .quo_o (nt)
  );
  // nt valid at stage DivStages+1

  // carry mode and original points along
  for (genvar s = 1; s < Lat-1; s++) begin : g_carry
    always_ff @(posedge clk_i) begin
      mode_q[s+1] <= mode_q[s];
      org_q[s+1]  <= org_q[s];
    end
  end

  // first split, three stages (2..4), keep right half
  tq_t  ta_q, tb_q;
  coord_t m01_q [2], m12_q [2], m23_q [2], p3_q [2];
  coord_t m012_q [2], m123_q [2], m23b_q [2], p3b_q [2];
  pts_t h_q;
  always_ff @(posedge clk_i) begin
    ta_q <= t1_q;
    tb_q <= ta_q;
    for (int c = 0; c < 2; c++) begin
      m01_q[c]  <= lerp(p_q[c][0], p_q[c][1], t1_q);
      m12_q[c]  <= lerp(p_q[c][1], p_q[c][2], t1_q);
      m23_q[c]  <= lerp(p_q[c][2], p_q[c][3], t1_q);
      p3_q[c]   <= p_q[c][3];
      m012_q[c] <= lerp(m01_q[c], m12_q[c], ta_q);
      m123_q[c] <= lerp(m12_q[c], m23_q[c], ta_q);
      m23b_q[c] <= m23_q[c];
      p3b_q[c]  <= p3_q[c];
      h_q[c][0] <= lerp(m012_q[c], m123_q[c], tb_q);
      h_q[c][1] <= m123_q[c];
      h_q[c][2] <= m23b_q[c];
      h_q[c][3] <= p3b_q[c];
    end
  end

  // delay right half until nt is ready
  localparam int unsigned HDly = DivStages + 1 - 4;
  pts_t hd_q [HDly+1];
  always_comb hd_q[0] = h_q;
  for (genvar s = 0; s < HDly; s++) begin : g_hdly
    always_ff @(posedge clk_i) hd_q[s+1] <= hd_q[s];
  end

  // second split, keep left half
  tq_t  na_q, nb_q;
  coord_t q0_q [2], n01_q [2], n12_q [2], n23_q [2];
  coord_t q0b_q [2], n01b_q [2], n012_q [2], n123_q [2];
  pts_t r_q;
  always_ff @(posedge clk_i) begin
    na_q <= nt;
    nb_q <= na_q;
    for (int c = 0; c < 2; c++) begin
      q0_q[c]   <= hd_q[HDly][c][0];
      n01_q[c]  <= lerp(hd_q[HDly][c][0], hd_q[HDly][c][1], nt);
      n12_q[c]  <= lerp(hd_q[HDly][c][1], hd_q[HDly][c][2], nt);
      n23_q[c]  <= lerp(hd_q[HDly][c][2], hd_q[HDly][c][3], nt);
      q0b_q[c]  <= q0_q[c];
      n01b_q[c] <= n01_q[c];
      n012_q[c] <= lerp(n01_q[c], n12_q[c], na_q);
      n123_q[c] <= lerp(n12_q[c], n23_q[c], na_q);
      r_q[c][0] <= q0b_q[c];
      r_q[c][1] <= n01b_q[c];
      r_q[c][2] <= n012_q[c];
      r_q[c][3] <= lerp(n012_q[c], n123_q[c], nb_q);
    end
  end

  // output select and register
  localparam int unsigned SelS = Lat - 1;
  pts_t res_d;
  always_comb begin
    case (mode_q[SelS])
      MODE_PASS:  res_d = org_q[SelS];
      MODE_END: begin
        for (int c = 0; c < 2; c++)
          for (int k = 0; k < 4; k++) res_d[c][k] = org_q[SelS][c][3];
      end
      MODE_START: begin
        for (int c = 0; c < 2; c++)
          for (int k = 0; k < 4; k++) res_d[c][k] = org_q[SelS][c][0];
      end
      default:    res_d = r_q;
    endcase
  end

  out_beat_t out_q;
  always_ff @(posedge clk_i) begin
    out_q <= '{res_d[0][0], res_d[1][0], res_d[0][1], res_d[1][1],
               res_d[0][2], res_d[1][2], res_d[0][3], res_d[1][3]};
  end
  assign out_o = out_q;

  a_busy_low: assert property (@(posedge clk_i) busy_o == 1'b0)
    else $error("busy raised");
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##(Lat) done_o) else $error("result missing");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Lat)) else $error("spurious result");

endmodule
